>>> rtl/tcal_pkg.sv
// Shared constants, tables and register codes for the triangle corner angle block.
package tcal_pkg;

    // Register indexes on the configuration port.
    typedef enum logic [0:0] {
        REG_FLOOR_LEN = 1'b0,
        REG_UNUSED    = 1'b1
    } reg_index_t;

    // Pipeline depth of one lane without its CORDIC iterations:
    // numerator, 30 division steps, sine argument, 31 root steps, CORDIC set-up, rounding.
    localparam int LANE_FIXED_STAGES = 65;
    localparam int DIV_STEPS         = 30;
    localparam int SQRT_STEPS        = 31;

    localparam logic [20:0]        FLOOR_LEN_RESET  = 21'd1;
    localparam logic signed [33:0] HALF_PI_Q30      = 34'sd1686629713;
    localparam logic signed [24:0] PI_Q20           = 25'sd3294199;
    localparam logic [22:0]        MINUS_ONE_Q20    = 23'h700000;

    // Arctangent of 2^-i in Q2.30.
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
        32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage

>>> rtl/triangle_corner_angles_from_lengths.sv
// Throughput: one face per cycle; every stage is a register and stalls only when the
// stages after it are full and the result is not taken.
// The three lanes each hold a 30-step divider, a 31-step square root and the CORDIC stages.
// Reset (aresetn low, synchronous) empties the pipeline and sets the shortest edge to 1.
// Top level: input checks, shared products, three corner lanes and the output merge.
module triangle_corner_angles_from_lengths #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [119:0] s_tdata,  // face_tag, len_first, len_second, len_third
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,  // face_tag_out, angle_first, angle_second, angle_third
    output logic         m_tuser   // degenerate
);

    localparam int LANE_ST = tcal_pkg::LANE_FIXED_STAGES + CORDIC_STEPS;
    localparam int LANE0   = 3;
    localparam int NST     = LANE0 + LANE_ST + 1;

    // Configuration register.
    logic [20:0] floor_len_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (tcal_pkg::reg_index_t'(paddr[2]) == tcal_pkg::REG_FLOOR_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_len_reg <= tcal_pkg::FLOOR_LEN_RESET;
        end else if (cfg_wr) begin
            floor_len_reg <= pwdata[20:0];
        end
    end

    always_comb begin
        unique case (tcal_pkg::reg_index_t'(paddr[2]))
            tcal_pkg::REG_FLOOR_LEN: prdata = {11'd0, floor_len_reg};
            default:                 prdata = '0;
        endcase
    end

    // Stage occupancy and the load enables: a stage loads when it or a later stage has room.
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] ld;

    always_comb begin
        ld[NST-1] = m_tready || !valid_reg[NST-1];
        for (int k = NST - 2; k >= 0; k--) begin
            ld[k] = ld[k+1] || !valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ld[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (ld[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = valid_reg[NST-1];

    // Input capture.
    logic [31:0] len_reg [3];
    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            len_reg[0] <= s_tdata[55:24];
            len_reg[1] <= s_tdata[87:56];
            len_reg[2] <= s_tdata[119:88];
        end
    end

    // Face tag and reject flag travel beside the lanes.
    logic [23:0] tag_reg   [0:NST-2];
    logic        degen_reg [1:NST-2];
    logic        degen_next;

    always_comb begin
        degen_next = (len_reg[0] < {11'd0, floor_len_reg}) ||
                     (len_reg[1] < {11'd0, floor_len_reg}) ||
                     (len_reg[2] < {11'd0, floor_len_reg}) ||
                     ({1'b0, len_reg[0]} + {1'b0, len_reg[1]} < {1'b0, len_reg[2]}) ||
                     ({1'b0, len_reg[0]} + {1'b0, len_reg[2]} < {1'b0, len_reg[1]}) ||
                     ({1'b0, len_reg[1]} + {1'b0, len_reg[2]} < {1'b0, len_reg[0]});
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            tag_reg[0] <= s_tdata[23:0];
        end
    end

    for (genvar k = 1; k <= NST - 2; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                tag_reg[k] <= tag_reg[k-1];
                if (k == 1) begin
                    degen_reg[k] <= degen_next;
                end else begin
                    degen_reg[k] <= degen_reg[k-1];
                end
            end
        end
    end

    // Halve all lengths when the largest reaches 2^31, rounding half up.
    logic [31:0] half_reg [3];
    logic        big;
    always_comb begin
        big = len_reg[0][31] || len_reg[1][31] || len_reg[2][31];
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            for (int i = 0; i < 3; i++) begin
                half_reg[i] <= big ? 32'(({1'b0, len_reg[i]} + 33'd1) >> 1) : len_reg[i];
            end
        end
    end

    // Shared squares and cross products.
    logic [63:0] sq_reg   [3];
    logic [63:0] prod_reg [3];  // ab, bc, ca
    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= half_reg[i] * half_reg[i];
            end
            prod_reg[0] <= half_reg[0] * half_reg[1];
            prod_reg[1] <= half_reg[1] * half_reg[2];
            prod_reg[2] <= half_reg[2] * half_reg[0];
        end
    end

    // Three lanes: each corner lies opposite the following edge.
    logic signed [22:0] lane_angle [3];

    tcal_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_first (
        .aclk     (aclk),
        .ld       (ld[LANE0 +: LANE_ST]),
        .opp_sq   (sq_reg[1]),
        .adj1_sq  (sq_reg[2]),
        .adj2_sq  (sq_reg[0]),
        .adj_prod (prod_reg[2]),
        .angle    (lane_angle[0])
    );

    tcal_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_second (
        .aclk     (aclk),
        .ld       (ld[LANE0 +: LANE_ST]),
        .opp_sq   (sq_reg[2]),
        .adj1_sq  (sq_reg[0]),
        .adj2_sq  (sq_reg[1]),
        .adj_prod (prod_reg[0]),
        .angle    (lane_angle[1])
    );

    tcal_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_third (
        .aclk     (aclk),
        .ld       (ld[LANE0 +: LANE_ST]),
        .opp_sq   (sq_reg[0]),
        .adj1_sq  (sq_reg[1]),
        .adj2_sq  (sq_reg[2]),
        .adj_prod (prod_reg[1]),
        .angle    (lane_angle[2])
    );

    // Merge: a rejected face reports minus one on every corner.
    logic [95:0] out_data_reg;
    logic        out_degen_reg;
    logic        fin_degen;

    assign fin_degen = degen_reg[NST-2];

    always_ff @(posedge aclk) begin
        if (ld[NST-1]) begin
            out_data_reg[23:0]  <= tag_reg[NST-2];
            out_data_reg[46:24] <= fin_degen ? tcal_pkg::MINUS_ONE_Q20 : lane_angle[0];
            out_data_reg[69:47] <= fin_degen ? tcal_pkg::MINUS_ONE_Q20 : lane_angle[1];
            out_data_reg[92:70] <= fin_degen ? tcal_pkg::MINUS_ONE_Q20 : lane_angle[2];
            out_data_reg[95:93] <= 3'd0;
            out_degen_reg       <= fin_degen;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_degen_reg;

    // A rejected face carries minus one on all three corners.
    a_degen_angles: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[46:24] == tcal_pkg::MINUS_ONE_Q20 &&
            m_tdata[69:47] == tcal_pkg::MINUS_ONE_Q20 &&
            m_tdata[92:70] == tcal_pkg::MINUS_ONE_Q20)
        else $error("rejected face without minus-one angles");

    // An accepted face gives angles within zero to pi.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            !m_tdata[46] && !m_tdata[69] && !m_tdata[92] &&
            m_tdata[46:24] <= 23'd3294199 && m_tdata[69:47] <= 23'd3294199 &&
            m_tdata[92:70] <= 23'd3294199)
        else $error("corner angle outside zero to pi");

    // Input is refused only when the whole pipeline is full and the result is stalled.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && (&valid_reg))
        else $error("input refused while the pipeline has room");

endmodule

>>> rtl/tcal_lane.sv
// One corner lane: cosine by restoring division, sine by square root, angle by CORDIC.
module tcal_lane #(
    parameter int CORDIC_STEPS = 24,
    localparam int NST = tcal_pkg::LANE_FIXED_STAGES + CORDIC_STEPS
) (
    input  logic                     aclk,
    input  logic [NST-1:0]           ld,
    input  logic [63:0]              opp_sq,
    input  logic [63:0]              adj1_sq,
    input  logic [63:0]              adj2_sq,
    input  logic [63:0]              adj_prod,
    output logic signed [22:0]       angle
);

    localparam int DS  = tcal_pkg::DIV_STEPS;
    localparam int SS  = tcal_pkg::SQRT_STEPS;
    localparam int SQ0 = DS + 1;          // sine argument stage
    localparam int CR0 = SQ0 + SS + 1;    // CORDIC set-up stage
    localparam int RND = CR0 + CORDIC_STEPS + 1;

    // Division pipeline: index 0 is the numerator stage.
    logic [63:0] mag_reg [0:DS];
    logic [63:0] den_reg [0:DS];
    logic [30:0] quo_reg [0:DS];
    logic        neg_reg [0:DS];
    logic        sat_reg [0:DS];

    logic [63:0] pq_sum;
    logic [63:0] num_mag_next;
    logic [63:0] den_next;
    logic        neg_next;

    // Numerator magnitude and sign, and the doubled product as divisor.
    always_comb begin
        pq_sum       = adj1_sq + adj2_sq;
        den_next     = {adj_prod[62:0], 1'b0};
        neg_next     = opp_sq > pq_sum;
        num_mag_next = neg_next ? (opp_sq - pq_sum) : (pq_sum - opp_sq);
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            mag_reg[0] <= num_mag_next;
            den_reg[0] <= den_next;
            neg_reg[0] <= neg_next;
            sat_reg[0] <= num_mag_next >= den_next;
            quo_reg[0] <= (num_mag_next >= den_next) ? 31'h40000000 : 31'd0;
        end
    end

    // One quotient bit per stage; a saturated cosine passes through untouched.
    for (genvar k = 1; k <= DS; k++) begin : g_div
        logic [64:0] rem2;
        logic [64:0] diff;
        logic        ge;
        always_comb begin
            rem2 = {mag_reg[k-1], 1'b0};
            diff = rem2 - {1'b0, den_reg[k-1]};
            ge   = rem2 >= {1'b0, den_reg[k-1]};
        end
        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                if (sat_reg[k-1]) begin
                    mag_reg[k] <= mag_reg[k-1];
                    quo_reg[k] <= quo_reg[k-1];
                end else begin
                    mag_reg[k] <= ge ? diff[63:0] : rem2[63:0];
                    quo_reg[k] <= {quo_reg[k-1][29:0], ge};
                end
            end
        end
    end

    // Square-root pipeline: index 0 holds the argument 2^60 - cos^2.
    logic [60:0]        rv_reg  [0:SS];
    logic [61:0]        res_reg [0:SS];
    logic signed [31:0] cos_reg [0:SS];
    logic [61:0]        cos_sq;
    logic [61:0]        sq_arg;

    always_comb begin
        cos_sq = quo_reg[DS] * quo_reg[DS];
        sq_arg = (62'd1 << 60) - cos_sq;
    end

    always_ff @(posedge aclk) begin
        if (ld[SQ0]) begin
            rv_reg[0]  <= sq_arg[60:0];
            res_reg[0] <= '0;
            cos_reg[0] <= neg_reg[DS] ? -$signed({1'b0, quo_reg[DS]})
                                      : $signed({1'b0, quo_reg[DS]});
        end
    end

    for (genvar j = 1; j <= SS; j++) begin : g_sqrt
        localparam logic [61:0] BIT = 62'd1 << (60 - 2 * (j - 1));
        logic [61:0] trial;
        logic        ge;
        always_comb begin
            trial = res_reg[j-1] + BIT;
            ge    = {1'b0, rv_reg[j-1]} >= trial;
        end
        always_ff @(posedge aclk) begin
            if (ld[SQ0+j]) begin
                cos_reg[j] <= cos_reg[j-1];
                if (ge) begin
                    rv_reg[j]  <= rv_reg[j-1] - trial[60:0];
                    res_reg[j] <= (res_reg[j-1] >> 1) + BIT;
                end else begin
                    rv_reg[j]  <= rv_reg[j-1];
                    res_reg[j] <= res_reg[j-1] >> 1;
                end
            end
        end
    end

    // CORDIC vectoring; a negative cosine is first turned by a quarter turn.
    logic signed [33:0] x_reg [0:CORDIC_STEPS];
    logic signed [33:0] y_reg [0:CORDIC_STEPS];
    logic signed [33:0] z_reg [0:CORDIC_STEPS];
    logic signed [33:0] sin_ext;
    logic signed [33:0] cos_ext;

    always_comb begin
        sin_ext = $signed({3'b000, res_reg[SS][30:0]});
        cos_ext = 34'(cos_reg[SS]);
    end

    always_ff @(posedge aclk) begin
        if (ld[CR0]) begin
            if (cos_ext < 0) begin
                x_reg[0] <= sin_ext;
                y_reg[0] <= -cos_ext;
                z_reg[0] <= tcal_pkg::HALF_PI_Q30;
            end else begin
                x_reg[0] <= cos_ext;
                y_reg[0] <= sin_ext;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [33:0] ATN = $signed({2'b00, tcal_pkg::ATAN_Q30[i-1]});
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        always_comb begin
            dx = y_reg[i-1] >>> (i - 1);
            dy = x_reg[i-1] >>> (i - 1);
        end
        always_ff @(posedge aclk) begin
            if (ld[CR0+i]) begin
                if (y_reg[i-1] >= 0) begin
                    x_reg[i] <= x_reg[i-1] + dx;
                    y_reg[i] <= y_reg[i-1] - dy;
                    z_reg[i] <= z_reg[i-1] + ATN;
                end else begin
                    x_reg[i] <= x_reg[i-1] - dx;
                    y_reg[i] <= y_reg[i-1] + dy;
                    z_reg[i] <= z_reg[i-1] - ATN;
                end
            end
        end
    end

    // Round Q2.30 to Q3.20 and clamp to [0, pi].
    logic signed [34:0] z_round;
    logic signed [24:0] z_q20;
    logic signed [22:0] angle_next;
    logic signed [22:0] angle_reg;

    always_comb begin
        z_round = 35'(z_reg[CORDIC_STEPS]) + 35'sd512;
        z_q20   = 25'(z_round >>> 10);
        if (z_q20 < 0) begin
            angle_next = '0;
        end else if (z_q20 > tcal_pkg::PI_Q20) begin
            angle_next = 23'(tcal_pkg::PI_Q20);
        end else begin
            angle_next = z_q20[22:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[RND]) begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule
